@@ design/dsd_pkg.sv @@
// ---------------------------------------------------------------------------
// dsd_pkg: shared types and constants for the DLE packet deframer
// Byte codes, result kinds, parser phases and the result record layout.
// ---------------------------------------------------------------------------
`default_nettype none

package dsd_pkg;

   // framing bytes
   localparam logic [7:0] DLE_BYTE = 8'h10;
   localparam logic [7:0] ETX_BYTE = 8'h03;

   // error codes carried in the value field
   localparam logic [7:0] ERR_BAD_START = 8'd0;
   localparam logic [7:0] ERR_OVERFLOW  = 8'd1;

   // reported data count saturates here
   localparam int unsigned COUNT_MAX = 511;

   // result queue depth
   localparam int unsigned OUTQ_DEPTH = 4;
   localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_ID    = 2'd0,
      KIND_DATA  = 2'd1,
      KIND_END   = 2'd2,
      KIND_ERROR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ID   = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic [8:0] data_count;
      logic       last_of_run;
   } rsp_item_type;

   // results caused by one request: count (0..2) and the two slots
   typedef struct packed {
      logic [1:0]   num;
      rsp_item_type item0;
      rsp_item_type item1;
   } step_out_type;

endpackage

`default_nettype wire

@@ design/dsd_step.sv @@
// ---------------------------------------------------------------------------
// dsd_step: per-byte deframing logic
// Given the parser state and one received byte, computes the next state and
// up to two result items.
// ---------------------------------------------------------------------------
`default_nettype none

module dsd_step #(
   parameter int MAX_PACKET_BYTES = 256,
   parameter int CW = 9
) (
   input  var dsd_pkg::phase_type    phase,
   input  var logic                  dle_parity,
   input  var logic                  dle_held,
   input  var logic [CW-1:0]         raw_count,
   input  var logic [CW-1:0]         body_count,
   input  var logic [7:0]            rx_byte,
   output dsd_pkg::phase_type        phase_nx,
   output logic                      dle_parity_nx,
   output logic                      dle_held_nx,
   output logic [CW-1:0]             raw_count_nx,
   output logic [CW-1:0]             body_count_nx,
   output dsd_pkg::step_out_type     step_out
);
   import dsd_pkg::*;

   logic          is_dle;
   logic          is_etx;
   logic          over;
   logic [CW-1:0] body_p1;
   logic [CW-1:0] body_p2;
   logic [8:0]    cnt_cur;
   logic [8:0]    cnt_p1;
   logic [8:0]    cnt_p2;

   // saturate a count to the reported range
   function automatic logic [8:0] clamp_count(input logic [31:0] c);
      logic [8:0] r;
      if (c > COUNT_MAX) r = 9'(COUNT_MAX);
      else               r = c[8:0];
      return r;
   endfunction

   assign is_dle  = (rx_byte == DLE_BYTE);
   assign is_etx  = (rx_byte == ETX_BYTE);
   assign over    = ({1'b0, raw_count} + (CW+1)'(1)) > (CW+1)'(MAX_PACKET_BYTES);
   assign body_p1 = body_count + CW'(1);
   assign body_p2 = body_count + CW'(2);
   assign cnt_cur = clamp_count(32'(body_count));
   assign cnt_p1  = clamp_count(32'(body_p1));
   assign cnt_p2  = clamp_count(32'(body_p2));

   // next state and results
   always_comb begin
      phase_nx      = phase;
      dle_parity_nx = dle_parity;
      dle_held_nx   = dle_held;
      raw_count_nx  = raw_count;
      body_count_nx = body_count;
      step_out      = '0;

      unique case (phase)
         PH_ID, PH_BODY: begin
            if (phase == PH_BODY && is_etx && !dle_parity) begin
               // closing etx: end of packet, held dle is the terminator
               step_out.num        = 2'd1;
               step_out.item0      = '{KIND_END, 8'd0, cnt_cur, 1'b1};
               phase_nx            = PH_IDLE;
               dle_parity_nx       = 1'b0;
               dle_held_nx         = 1'b0;
               raw_count_nx        = '0;
               body_count_nx       = '0;
            end else if (over) begin
               // packet too long: drop it
               step_out.num        = 2'd1;
               step_out.item0      = '{KIND_ERROR, ERR_OVERFLOW, cnt_cur, 1'b1};
               phase_nx            = PH_IDLE;
               dle_parity_nx       = 1'b0;
               dle_held_nx         = 1'b0;
               raw_count_nx        = '0;
               body_count_nx       = '0;
            end else begin
               raw_count_nx  = raw_count + CW'(1);
               dle_parity_nx = dle_parity ^ is_dle;
               if (phase == PH_ID) begin
                  // packet id
                  phase_nx       = PH_BODY;
                  step_out.num   = 2'd1;
                  step_out.item0 = '{KIND_ID, rx_byte, cnt_cur, 1'b1};
               end else if (dle_held) begin
                  dle_held_nx = 1'b0;
                  if (is_dle) begin
                     // stuffed pair becomes one dle data byte
                     body_count_nx  = body_p1;
                     step_out.num   = 2'd1;
                     step_out.item0 = '{KIND_DATA, DLE_BYTE, cnt_p1, 1'b1};
                  end else begin
                     // held dle and this byte both go out as data
                     body_count_nx  = body_p2;
                     step_out.num   = 2'd2;
                     step_out.item0 = '{KIND_DATA, DLE_BYTE, cnt_p1, 1'b0};
                     step_out.item1 = '{KIND_DATA, rx_byte, cnt_p2, 1'b1};
                  end
               end else if (is_dle) begin
                  // hold until the next byte decides
                  dle_held_nx = 1'b1;
               end else begin
                  body_count_nx  = body_p1;
                  step_out.num   = 2'd1;
                  step_out.item0 = '{KIND_DATA, rx_byte, cnt_p1, 1'b1};
               end
            end
         end
         default: begin
            // idle, also the unused phase code
            dle_held_nx   = 1'b0;
            body_count_nx = '0;
            if (is_dle) begin
               phase_nx      = PH_ID;
               dle_parity_nx = 1'b1;
               raw_count_nx  = CW'(1);
            end else begin
               phase_nx       = PH_IDLE;
               dle_parity_nx  = 1'b0;
               raw_count_nx   = '0;
               step_out.num   = 2'd1;
               step_out.item0 = '{KIND_ERROR, ERR_BAD_START, 9'd0, 1'b1};
            end
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/dsd_outq.sv @@
// ---------------------------------------------------------------------------
// dsd_outq: result queue
// Small register queue that takes up to two results per cycle and hands one
// per cycle to the result channel while head_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module dsd_outq (
   input  var logic                  clock,
   input  var logic                  reset,
   input  var dsd_pkg::step_out_type push,
   output logic                      room2,
   output logic                      head_valid,
   input  var logic                  head_ready,
   output dsd_pkg::rsp_item_type     head,
   output logic [dsd_pkg::OUTQ_CNT_W-1:0] level
);
   import dsd_pkg::*;

   rsp_item_type          mem_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CNT_W-1:0] count_ff, count_in;
   logic                  pop;

   assign pop        = head_valid && head_ready;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign room2      = (count_ff <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
   assign level      = count_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUTQ_PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + OUTQ_PTR_W'(pop);
      count_in  = count_ff + OUTQ_CNT_W'(push.num) - OUTQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) mem_ff[wr_ptr_ff] <= push.item0;
      if (push.num == 2'd2) mem_ff[wr_ptr_ff + OUTQ_PTR_W'(1)] <= push.item1;
   end

endmodule

`default_nettype wire

@@ design/dle_stuffed_packet_deframer.sv @@
// ---------------------------------------------------------------------------
// dle_stuffed_packet_deframer: DLE id data DLE ETX packet deframer
// Takes raw serial bytes and reports packet id, destuffed data, packet end
// and errors as a stream of result items.
// ---------------------------------------------------------------------------
// Usage:
//  - req_ channel: one raw byte per request (req_rx_byte).
//  - rsp_ channel: result items (kind, value, data_count, last_of_run); a
//    request gives zero, one or two results, the last one flagged.
//  - Each result is registered in the queue and offered on rsp_ behind any older results.
//  - Throughput: one byte per clock while rsp_ready is high and each
//    byte yields at most one result; a byte that releases a held DLE plus
//    itself yields two, and the result channel drains one per ready cycle.
//  - The parser state updates in the accepting cycle; results go to a
//    four-entry queue. req_ready is high while the queue has room for two,
//    so a stalled receiver stops intake once three or more results wait.
//  - Reset (synchronous) returns the parser to idle and empties the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module dle_stuffed_packet_deframer #(
   parameter int MAX_PACKET_BYTES = 256
) (
   input  var logic       clock,
   input  var logic       reset,
   input  var logic       req_valid,
   output logic           req_ready,
   input  var logic [7:0] req_rx_byte,
   output logic           rsp_valid,
   input  var logic       rsp_ready,
   output logic [1:0]     rsp_kind,
   output logic [7:0]     rsp_value,
   output logic [8:0]     rsp_data_count,
   output logic           rsp_last_of_run
);
   import dsd_pkg::*;

   localparam int CW = $clog2(MAX_PACKET_BYTES + 2);

   phase_type     phase_ff, phase_in, phase_nx;
   logic          dle_parity_ff, dle_parity_in, dle_parity_nx;
   logic          dle_held_ff, dle_held_in, dle_held_nx;
   logic [CW-1:0] raw_count_ff, raw_count_in, raw_count_nx;
   logic [CW-1:0] body_count_ff, body_count_in, body_count_nx;
   step_out_type  step_out;
   step_out_type  push;
   rsp_item_type  head;
   logic          accept;
   logic [OUTQ_CNT_W-1:0] q_level;

   assign accept = req_valid && req_ready;

   // per-byte parser logic
   dsd_step #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
      .CW(CW)
   ) u_step (
      .phase(phase_ff),
      .dle_parity(dle_parity_ff),
      .dle_held(dle_held_ff),
      .raw_count(raw_count_ff),
      .body_count(body_count_ff),
      .rx_byte(req_rx_byte),
      .phase_nx(phase_nx),
      .dle_parity_nx(dle_parity_nx),
      .dle_held_nx(dle_held_nx),
      .raw_count_nx(raw_count_nx),
      .body_count_nx(body_count_nx),
      .step_out(step_out)
   );

   // state advances only on an accepted request
   always_comb begin
      phase_in      = accept ? phase_nx      : phase_ff;
      dle_parity_in = accept ? dle_parity_nx : dle_parity_ff;
      dle_held_in   = accept ? dle_held_nx   : dle_held_ff;
      raw_count_in  = accept ? raw_count_nx  : raw_count_ff;
      body_count_in = accept ? body_count_nx : body_count_ff;
      push          = accept ? step_out      : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         dle_parity_ff <= 1'b0;
         dle_held_ff   <= 1'b0;
         raw_count_ff  <= '0;
         body_count_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         dle_parity_ff <= dle_parity_in;
         dle_held_ff   <= dle_held_in;
         raw_count_ff  <= raw_count_in;
         body_count_ff <= body_count_in;
      end
   end

   // result queue
   dsd_outq u_outq (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room2(req_ready),
      .head_valid(rsp_valid),
      .head_ready(rsp_ready),
      .head(head),
      .level(q_level)
   );

   assign rsp_kind        = head.kind;
   assign rsp_value       = head.value;
   assign rsp_data_count  = head.data_count;
   assign rsp_last_of_run = head.last_of_run;

`ifndef NO_ASSERTIONS
   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_level <= OUTQ_CNT_W'(OUTQ_DEPTH))
      else $error("result queue over capacity");

   // a request is only taken when two results fit
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> (q_level <= OUTQ_CNT_W'(OUTQ_DEPTH - 2)))
      else $error("request accepted without queue room");

   // in the body the opening dle and id are already counted
   a_body_raw: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (raw_count_ff >= CW'(2)))
      else $error("body phase with short raw count");

   // a dle is only held inside a packet body
   a_held_body: assert property (@(posedge clock) disable iff (reset)
      dle_held_ff |-> (phase_ff == PH_BODY))
      else $error("dle held outside packet body");

   // reset empties the result channel
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");
`endif

endmodule

`default_nettype wire
